>>> hdl/assert_macros.svh
// Assertion helpers for the sorted table unit.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted table check failed");

// Next-cycle implication.
`define STI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted table check failed");

`endif

>>> hdl/sti_pkg.sv
`timescale 1ns / 1ps

package sti_pkg;

    localparam int VALUE_W   = 32;
    localparam int FILL_W    = 5;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    typedef struct packed {
        logic latch;  // capture the incoming request
        logic exec;   // perform the operation and load its result
        logic step;   // emit the head entry and rotate the table
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              step_last;
    } t_sts;

    // Flip the sign bit so signed order becomes unsigned order.
    function automatic logic [VALUE_W-1:0] key_of(input logic [VALUE_W-1:0] x);
        return {~x[VALUE_W-1], x[VALUE_W-2:0]};
    endfunction

endpackage

>>> hdl/sti_ctrl.sv
`timescale 1ns / 1ps

module sti_ctrl
    import sti_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    input  logic i_m_ready,
    input  t_sts i_sts,
    output logic o_s_ready,
    output logic o_m_valid,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_DUMP = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_m_valid, n_m_valid;
    logic       out_free;

    assign out_free  = !r_m_valid || i_m_ready;
    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_m_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.kind == KIND_DUMP && !i_sts.empty) begin
                    n_state = ST_DUMP;
                end else if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_sts.step_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.exec || o_cmd.step) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

endmodule

>>> hdl/sti_dp.sv
`timescale 1ns / 1ps

module sti_dp
    import sti_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [KIND_W-1:0]      i_kind,
    input  logic [VALUE_W-1:0]     i_value,
    output t_sts                   o_sts,
    output logic [$clog2(CAPACITY+1)-1:0] o_occ,
    output logic [STATUS_W-1:0]    o_status,
    output logic [VALUE_W-1:0]     o_entry,
    output logic [FILL_W-1:0]      o_fill,
    output logic                   o_last
);

    localparam int OW = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0]  r_cell [CAPACITY];
    logic [VALUE_W-1:0]  n_cell [CAPACITY];
    logic [OW-1:0]       r_occ, n_occ;
    logic [OW-1:0]       r_idx;
    logic [KIND_W-1:0]   r_kind;
    logic [VALUE_W-1:0]  r_value;

    logic [STATUS_W-1:0] r_status, n_status;
    logic [VALUE_W-1:0]  r_entry, n_entry;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                r_last, n_last;

    logic [CAPACITY-1:0] valid, gt, lt, match;
    logic                found, full, empty, step_last;

    assign full      = (r_occ == OW'(CAPACITY));
    assign empty     = (r_occ == '0);
    assign step_last = (r_idx == r_occ - OW'(1));
    assign found     = |match;

    assign o_sts.kind      = r_kind;
    assign o_sts.empty     = empty;
    assign o_sts.step_last = step_last;
    assign o_occ    = r_occ;
    assign o_status = r_status;
    assign o_entry  = r_entry;
    assign o_fill   = r_fill;
    assign o_last   = r_last;

    // Per-cell compare against the request value.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            valid[i] = (r_occ > OW'(i));
            gt[i]    = !valid[i] || (key_of(r_cell[i]) > key_of(r_value));
            lt[i]    = valid[i] && (key_of(r_cell[i]) < key_of(r_value));
        end
        match[0] = valid[0] && !lt[0] && (r_cell[0] == r_value);
        for (int i = 1; i < CAPACITY; i++) begin
            match[i] = valid[i] && !lt[i] && lt[i-1] && (r_cell[i] == r_value);
        end
    end

    always_comb begin
        n_cell   = r_cell;
        n_occ    = r_occ;
        n_status = r_status;
        n_entry  = r_entry;
        n_fill   = r_fill;
        n_last   = r_last;
        if (i_cmd.exec) begin
            n_entry  = '0;
            n_last   = 1'b1;
            n_status = STAT_DONE;
            unique case (r_kind)
                KIND_INSERT: begin
                    if (full) begin
                        n_status = STAT_FULL;
                    end else begin
                        // Open a slot at the first greater entry, shift the rest up.
                        if (gt[0]) begin
                            n_cell[0] = r_value;
                        end
                        for (int i = 1; i < CAPACITY; i++) begin
                            if (gt[i]) begin
                                n_cell[i] = gt[i-1] ? r_cell[i-1] : r_value;
                            end
                        end
                        n_occ = r_occ + OW'(1);
                    end
                end
                KIND_DELETE: begin
                    if (found) begin
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            if (!lt[i]) begin
                                n_cell[i] = r_cell[i+1];
                            end
                        end
                        n_occ = r_occ - OW'(1);
                    end else begin
                        n_status = STAT_NOT_FOUND;
                    end
                end
                KIND_CLEAR: n_occ = '0;
                KIND_DUMP:  n_status = STAT_EMPTY;
                default:    n_status = STAT_DONE;
            endcase
            n_fill = FILL_W'(n_occ);
        end else if (i_cmd.step) begin
            n_status = STAT_DONE;
            n_entry  = r_cell[0];
            n_fill   = FILL_W'(r_occ);
            n_last   = step_last;
            // Rotate the held entries so the next one reaches the head.
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_occ > OW'(i + 1)) begin
                    n_cell[i] = (i + 1 < CAPACITY) ? r_cell[(i + 1) % CAPACITY] : r_cell[i];
                end else if (r_occ == OW'(i + 1)) begin
                    n_cell[i] = r_cell[0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_idx  <= '0;
            r_kind <= KIND_INSERT;
        end else begin
            r_occ <= n_occ;
            if (i_cmd.latch) begin
                r_kind <= i_kind;
                r_idx  <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell   <= n_cell;
        r_status <= n_status;
        r_entry  <= n_entry;
        r_fill   <= n_fill;
        r_last   <= n_last;
        if (i_cmd.latch) begin
            r_value <= i_value;
        end
    end

endmodule

>>> hdl/sorted_table_insert_delete_unit.sv
// Insert, delete and clear: one result, registered in the exec state once the request is latched
// and the output is free; the compare-and-shift cells work on all entries at once.
// Dump: one entry per cycle as the table rotates, while the output is free. No new request is taken until one is done.
// Reset (synchronous, active low) empties the table and idles the controller;
// stored entries themselves are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_table_insert_delete_unit
    import sti_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [31:0] value
    input  logic [KIND_W-1:0]     s_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [31:0] entry, [36:32] fill, [39:37] zero
    output logic [STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
    output logic                  m_axis_tlast
);

    localparam int OW = $clog2(CAPACITY + 1);

    t_cmd                cmd;
    t_sts                sts;
    logic [OW-1:0]       occ;
    logic [VALUE_W-1:0]  entry;
    logic [FILL_W-1:0]   fill;

    sti_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (cmd)
    );

    sti_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_kind   (s_axis_tuser),
        .i_value  (s_axis_tdata),
        .o_sts    (sts),
        .o_occ    (occ),
        .o_status (m_axis_tuser),
        .o_entry  (entry),
        .o_fill   (fill),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {(M_TDATA_W - FILL_W - VALUE_W)'(0), fill, entry};

    `STI_ASSERT_IMP(a_occ_bound, 1'b1, occ <= OW'(CAPACITY))
    `STI_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `STI_ASSERT_IMP(a_empty_zero_fill, m_axis_tvalid && m_axis_tuser == STAT_EMPTY, fill == '0 && entry == '0)

endmodule

>>> tb/tb_sorted_table_insert_delete_unit.sv
`timescale 1ns / 1ps

module tb_sorted_table_insert_delete_unit;
    import sti_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 24;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  entry;
        logic [FILL_W-1:0]   fill;
        logic                last;
    } t_table_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;   // [31:0] value
    logic [KIND_W-1:0]    s_axis_tuser;   // [1:0] kind
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;   // [31:0] entry, [36:32] fill, [39:37] zero
    logic [STATUS_W-1:0]  m_axis_tuser;   // [1:0] status
    logic                 m_axis_tlast;

    // Shadow of the table as the block should hold it
    logic signed [VALUE_W-1:0] sorted_copy [CAPACITY];
    int                        copy_fill;
    t_table_result             awaited_results [$];
    logic [VALUE_W-1:0]        inserted_values [$];

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int n_requests;
    int n_results;
    int n_full_drops;
    int longest_dump;

    sorted_table_insert_delete_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Work out the results one request should produce and update the shadow table.
    function automatic void predict_table_op(input logic [KIND_W-1:0] kind,
                                             input logic signed [VALUE_W-1:0] value);
        t_table_result r;
        int            pos;
        int            i;
        r.status = STAT_DONE;
        r.entry  = '0;
        r.fill   = '0;
        r.last   = 1'b1;
        case (kind)
            KIND_INSERT: begin
                if (copy_fill >= CAPACITY) begin
                    r.status = STAT_FULL;
                    n_full_drops++;
                end else begin
                    // land after any equal entries
                    pos = 0;
                    while (pos < copy_fill && sorted_copy[pos] <= value) pos++;
                    for (i = copy_fill; i > pos; i--) sorted_copy[i] = sorted_copy[i - 1];
                    sorted_copy[pos] = value;
                    copy_fill++;
                end
                r.fill = copy_fill[FILL_W-1:0];
                awaited_results.push_back(r);
            end
            KIND_DELETE: begin
                pos = 0;
                while (pos < copy_fill && sorted_copy[pos] < value) pos++;
                if (pos >= copy_fill || sorted_copy[pos] != value) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    for (i = pos; i + 1 < copy_fill; i++) sorted_copy[i] = sorted_copy[i + 1];
                    copy_fill--;
                end
                r.fill = copy_fill[FILL_W-1:0];
                awaited_results.push_back(r);
            end
            KIND_CLEAR: begin
                copy_fill = 0;
                awaited_results.push_back(r);
            end
            KIND_DUMP: begin
                if (copy_fill == 0) begin
                    r.status = STAT_EMPTY;
                    awaited_results.push_back(r);
                end else begin
                    for (i = 0; i < copy_fill; i++) begin
                        r.entry = sorted_copy[i];
                        r.fill  = copy_fill[FILL_W-1:0];
                        r.last  = (i + 1 == copy_fill);
                        awaited_results.push_back(r);
                    end
                    if (copy_fill > longest_dump) longest_dump = copy_fill;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_table_result want;
        if (!i_rst_n) begin
            copy_fill = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_table_op(s_axis_tuser, s_axis_tdata);
                n_requests++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0h entry %0h fill %0d last %0b",
                           m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32],
                           m_axis_tlast);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", VALUE_W'(want.status), VALUE_W'(m_axis_tuser));
                    check_field("entry", want.entry, m_axis_tdata[31:0]);
                    check_field("fill", VALUE_W'(want.fill), VALUE_W'(m_axis_tdata[36:32]));
                    check_field("last", VALUE_W'(want.last), VALUE_W'(m_axis_tlast));
                    check_field("pad", '0, VALUE_W'(m_axis_tdata[39:37]));
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Hold off the sender until every awaited result is back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(1) == 0) begin
            case ($urandom_range(7))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                4: return 32'h0000_0001;
                5: return 32'h0000_002A;
                6: return 32'hFFFF_FFD6;
                default: return 32'h7FFF_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic test_directed_ops();
        send_request(KIND_DUMP, 32'hDEAD_BEEF);     // empty table
        send_request(KIND_DELETE, 32'h0000_0005);   // nothing to find
        send_request(KIND_INSERT, 32'h7FFF_FFFF);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);   // duplicate
        send_request(KIND_DELETE, 32'h0000_0007);   // falls between entries
        send_request(KIND_DELETE, 32'hFFFF_FFFF);   // one of the pair
        send_request(KIND_DUMP, 32'h0000_0000);
    endtask

    task automatic test_full_table();
        logic [VALUE_W-1:0] fill_values [13];
        int k;
        fill_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
                        32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000,
                        32'h7FFF_FFFE, 32'h8000_0001, 32'h1234_5678, 32'hEDCB_A987,
                        32'h7FFF_FFFF};
        for (k = 0; k < 13; k++) send_request(KIND_INSERT, fill_values[k]);
        send_request(KIND_INSERT, 32'h0000_0003);   // table is full: dropped
        send_request(KIND_DUMP, 32'hFFFF_FFFF);
        send_request(KIND_CLEAR, 32'hA5A5_A5A5);
    endtask

    task automatic test_random(input int count, input bit with_pause);
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        int                 roll;
        int                 n;
        for (n = 0; n < count; n++) begin
            roll  = $urandom_range(99);
            value = pick_value();
            if (roll < 48) begin
                kind = KIND_INSERT;
                inserted_values.push_back(value);
                if (inserted_values.size() > CAPACITY) void'(inserted_values.pop_front());
            end else if (roll < 76) begin
                kind = KIND_DELETE;
                // mostly aim at values that are likely held
                if (inserted_values.size() != 0 && $urandom_range(3) != 0)
                    value = inserted_values[$urandom_range(inserted_values.size() - 1)];
            end else if (roll < 80) begin
                kind = KIND_CLEAR;
            end else begin
                kind = KIND_DUMP;
            end
            send_request(kind, value);
            if (with_pause && n == count / 2) drain_results();
        end
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_INSERT;
        i_rst_n       <= 1'b0;
        send_idle_pct  = 30;
        recv_stall_pct = 45;
        errors         = 0;
        n_requests     = 0;
        n_results      = 0;
        n_full_drops   = 0;
        longest_dump   = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_full_table();
        test_random(62, 1'b1);
        send_idle_pct  = 45;
        recv_stall_pct = 30;
        test_random(62, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(62, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $error("%0d expected results never arrived", awaited_results.size());
            errors++;
        end

        $display("Sent %0d requests and checked %0d results across three idle/stall mixes.",
                 n_requests, n_results);
        $display("Saw %0d inserts dropped on a full table; longest dump was %0d entries.",
                 n_full_drops, longest_dump);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sti_pkg.sv
hdl/sti_ctrl.sv
hdl/sti_dp.sv
hdl/sorted_table_insert_delete_unit.sv
tb/tb_sorted_table_insert_delete_unit.sv
